// ===== rtl/hxfp_pkg.sv =====
// Shared types and constants for the header/XOR checked frame parser.
// Used by every module under rtl/; depends on nothing.
package hxfp_pkg;

	localparam int DEF_FRAME_BYTES = 8;
	localparam int BYTE_W          = 8;
	localparam int IDX_W           = 6;
	localparam int MAX_FRAME_BYTES = 1 << IDX_W;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [IDX_W-1:0]  idx_t;

	// front -> frame buffer write side
	typedef struct packed {
		logic  en;
		idx_t  idx;
		byte_t data;
		logic  commit;
	} hxfp_wr_t;

	// back -> frame buffer read side
	typedef struct packed {
		logic en;
		idx_t idx;
		logic done;
	} hxfp_rd_t;

endpackage

// ===== rtl/hxfp_front.sv =====
// Front part: hunts for the header, stores payload beats, checks the XOR.
// Depends on hxfp_pkg; writes into hxfp_frame_buf.
module hxfp_front #(
	parameter int FRAME_BYTES = hxfp_pkg::DEF_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                header_we,
	input  hxfp_pkg::byte_t     header_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  hxfp_pkg::byte_t     s_tdata,
	input  logic                wr_free,
	output hxfp_pkg::hxfp_wr_t  wr
);
	import hxfp_pkg::*;

	localparam int PH_W = $clog2(FRAME_BYTES + 2);
	localparam logic [PH_W-1:0] PH_HUNT  = '0;
	localparam logic [PH_W-1:0] PH_CHECK = PH_W'(FRAME_BYTES + 1);

	logic [PH_W-1:0] phase_q;
	byte_t           xor_q;
	byte_t           header_q;
	logic            acc;

	assign s_tready = (phase_q == PH_HUNT) || wr_free;
	assign acc      = s_tvalid && s_tready;

	always_comb begin
		wr.en     = acc && (phase_q != PH_HUNT) && (phase_q != PH_CHECK);
		wr.idx    = IDX_W'(phase_q - PH_W'(1));
		wr.data   = s_tdata;
		wr.commit = acc && (phase_q == PH_CHECK) && (s_tdata == xor_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q <= '0;
		end else if (header_we) begin
			header_q <= header_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			xor_q   <= '0;
		end else if (acc) begin
			if (phase_q == PH_HUNT) begin
				if (s_tdata == header_q) begin
					phase_q <= PH_W'(1);
					xor_q   <= '0;
				end
			end else if (phase_q == PH_CHECK) begin
				phase_q <= PH_HUNT;
			end else begin
				phase_q <= phase_q + PH_W'(1);
				xor_q   <= xor_q ^ s_tdata;
			end
		end
	end

endmodule

// ===== rtl/hxfp_frame_buf.sv =====
// Two-frame queue between front and back: payload memory in two banks.
// Depends on hxfp_pkg; written by hxfp_front, read by hxfp_back.
module hxfp_frame_buf #(
	parameter int FRAME_BYTES = hxfp_pkg::DEF_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hxfp_pkg::hxfp_wr_t  wr,
	output logic                wr_free,
	input  hxfp_pkg::hxfp_rd_t  rd,
	output logic                rd_avail,
	output hxfp_pkg::byte_t     rd_data
);
	import hxfp_pkg::*;

	localparam int IW    = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
	localparam int DEPTH = 2 << IW;

	byte_t      mem [DEPTH];
	byte_t      rd_data_q;
	logic [1:0] full_q;
	logic [1:0] full_d;
	logic       wr_bank_q;
	logic       rd_bank_q;

	assign wr_free  = !full_q[wr_bank_q];
	assign rd_avail = full_q[rd_bank_q];
	assign rd_data  = rd_data_q;

	always_comb begin
		full_d = full_q;
		if (wr.commit) begin
			full_d[wr_bank_q] = 1'b1;
		end
		if (rd.en && rd.done) begin
			full_d[rd_bank_q] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[{wr_bank_q, wr.idx[IW-1:0]}] <= wr.data;
		end
		if (rd.en) begin
			rd_data_q <= mem[{rd_bank_q, rd.idx[IW-1:0]}];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= '0;
			wr_bank_q <= 1'b0;
			rd_bank_q <= 1'b0;
		end else begin
			full_q <= full_d;
			if (wr.commit) begin
				wr_bank_q <= !wr_bank_q;
			end
			if (rd.en && rd.done) begin
				rd_bank_q <= !rd_bank_q;
			end
		end
	end

endmodule

// ===== rtl/hxfp_back.sv =====
// Back part: walks a committed frame and drives the output beats.
// Depends on hxfp_pkg; reads from hxfp_frame_buf.
module hxfp_back #(
	parameter int FRAME_BYTES = hxfp_pkg::DEF_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_avail,
	input  hxfp_pkg::byte_t     rd_data,
	output hxfp_pkg::hxfp_rd_t  rd,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,
	output logic                m_tlast
);
	import hxfp_pkg::*;

	localparam idx_t LAST_IDX = IDX_W'(FRAME_BYTES - 1);

	idx_t  cnt_q;
	logic  valid_s1;
	idx_t  idx_s1;
	logic  last_s1;
	logic  out_valid_q;
	byte_t out_byte_q;
	idx_t  out_idx_q;
	logic  out_last_q;
	logic  adv;
	logic  issue;

	assign adv   = valid_s1 && (!out_valid_q || m_tready);
	assign issue = rd_avail && (!valid_s1 || adv);

	always_comb begin
		rd.en   = issue;
		rd.idx  = cnt_q;
		rd.done = (cnt_q == LAST_IDX);
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {2'b00, out_idx_q, out_byte_q};
	assign m_tlast  = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
				cnt_q    <= (cnt_q == LAST_IDX) ? '0 : cnt_q + IDX_W'(1);
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			idx_s1  <= cnt_q;
			last_s1 <= (cnt_q == LAST_IDX);
		end
		if (adv) begin
			out_byte_q <= rd_data;
			out_idx_q  <= idx_s1;
			out_last_q <= last_s1;
		end
	end

endmodule

// ===== rtl/header_xor_checked_frame_parser.sv =====
// Top level of the header/XOR checked frame parser.
// Depends on hxfp_pkg, hxfp_front, hxfp_frame_buf, hxfp_back.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    s_tdata[7:0] rx_byte
//  m_*       out  m_tvalid/m_tready    m_tdata[7:0] payload_byte, [13:8] byte_index;
//                                      m_tlast last_of_frame
//  header_*  in   header_we            header_data[7:0]
//
// Input takes one beat per cycle while s_tready is high; output gives one beat per
// cycle while m_tready is high, via the bank flag, the read and the output register.
// The two payload banks hold two frames; s_tready drops inside a frame only
// when both banks wait on the output side.
// arst_n clears the parser, bank flags and output valid; the header register resets to 0.
module header_xor_checked_frame_parser #(
	parameter int FRAME_BYTES = hxfp_pkg::DEF_FRAME_BYTES
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                header_we,
	input  hxfp_pkg::byte_t     header_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  hxfp_pkg::byte_t     s_tdata,   // [7:0] rx_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,   // [7:0] payload_byte, [13:8] byte_index
	output logic                m_tlast
);
	import hxfp_pkg::*;

	hxfp_wr_t wr;
	hxfp_rd_t rd;
	logic     wr_free;
	logic     rd_avail;
	byte_t    rd_data;

	hxfp_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.header_we   (header_we),
		.header_data (header_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.wr_free     (wr_free),
		.wr          (wr)
	);

	hxfp_frame_buf #(.FRAME_BYTES(FRAME_BYTES)) u_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (wr),
		.wr_free  (wr_free),
		.rd       (rd),
		.rd_avail (rd_avail),
		.rd_data  (rd_data)
	);

	hxfp_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_avail (rd_avail),
		.rd_data  (rd_data),
		.rd       (rd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTHESIS
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[13:8] == IDX_W'(FRAME_BYTES - 1))
		else $error("tlast beat not at final payload index");

	a_wr_bank_free: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en || wr.commit |-> wr_free)
		else $error("payload write into a bank still held");

	a_rd_bank_full: assert property (@(posedge clk) disable iff (!arst_n)
		rd.en |-> rd_avail)
		else $error("payload read from an empty bank");
`endif

endmodule
